>>> hw/rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// Line segment sampler package
// Shared types and fixed constants for the line segment sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  // Signed Q15.8 coordinate.
  typedef logic signed [23:0] coord_t;

  // Unsigned Q8.8 sample spacing.
  typedef logic [15:0] spacing_t;

  // Point index within a segment and the point count.
  typedef logic [5:0] index_t;
  typedef logic [6:0] count_t;

  localparam int CountW = 7;
  localparam int IndexW = 6;

  // Spacing register value after reset (1.0 in Q8.8).
  localparam spacing_t SpacingReset = 16'd256;

  // Width of a coordinate difference and of its square sums.
  localparam int DiffW = 25;
  localparam int ProdW = 2 * DiffW;

  // Quotient bits produced by the restoring divider, one per cycle.
  localparam int DivSteps = DiffW;

endpackage : lss_pkg

`default_nettype wire

>>> hw/rtl/lss_ifs.sv
// ----------------------------------------------------------------------------
// Line segment sampler channels
// Valid/ready channels for segments in and sampled points out.
// ----------------------------------------------------------------------------
`default_nettype none

// Segment channel: one item is one segment.
interface lss_seg_if;
  import lss_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface : lss_seg_if

// Point channel: one item is one sampled point.
interface lss_pt_if;
  import lss_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  index_t sample_index;
  count_t sample_count;
  logic   clipped;
  logic   last;

  modport source (output valid, output point_x, output point_y,
                  output sample_index, output sample_count,
                  output clipped, output last, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input sample_index, input sample_count,
                  input clipped, input last, output ready);
endinterface : lss_pt_if

`default_nettype wire

>>> hw/rtl/line_segment_sampler.sv
// ----------------------------------------------------------------------------
// Line segment sampler
// Splits a segment into n evenly spaced points, n chosen from the spacing.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake         Contents
//   seg       in   valid/ready       start_x, start_y, end_x, end_y
//   pt        out  valid/ready       point, index, count, clipped, last
//   cfg       in   cfg_we            spacing (cfg_wdata)
//
// A segment passes from accept to accept through idle, two squaring steps and a binary search
// of n with two passes per probe, all on one shared 25x25 multiplier, a 25 step divide on both
// axes, a sign fix-up, then one point per cycle while the point channel is not stalled. Reset is
// synchronous; it clears control state and sets spacing to 1.0.
// A stalled point channel holds the point stage; seg.ready stays low until the last point
// of a segment has been loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_sampler #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire lss_pkg::spacing_t cfg_wdata,
  lss_seg_if.sink               seg,
  lss_pt_if.source              pt
);
  import lss_pkg::*;

  localparam count_t MaxCount  = count_t'(MAX_SAMPLES);
  localparam count_t NoneFound = count_t'(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_LEN,
    S_CMP,
    S_DIV,
    S_FIX,
    S_EMIT
  } state_t;

  state_t                    state;
  spacing_t                  spacing;

  // Segment registers.
  coord_t                    sx;
  coord_t                    sy;
  logic signed [DiffW-1:0]   dx;
  logic signed [DiffW-1:0]   dy;

  // Count search registers.
  logic [ProdW-1:0]          acc;
  logic [ProdW-1:0]          d2;
  count_t                    lo;
  count_t                    hi;
  count_t                    mid;
  logic [DiffW-1:0]          len;
  count_t                    n;
  logic                      clip;

  // Divider registers (quotient shifts into the dividend register).
  logic [DiffW-1:0]          ax;
  logic [DiffW-1:0]          ay;
  logic [CountW-1:0]         rx;
  logic [CountW-1:0]         ry;
  logic [4:0]                dcnt;

  // Step registers for the point walk.
  logic signed [DiffW:0]     qx;
  logic signed [DiffW:0]     qy;
  logic [CountW:0]           r2x;
  logic [CountW:0]           r2y;
  logic signed [DiffW-1:0]   px;
  logic signed [DiffW-1:0]   py;
  logic [CountW:0]           rrx;
  logic [CountW:0]           rry;
  count_t                    k;

  // Output registers.
  logic                      out_valid;
  coord_t                    out_x;
  coord_t                    out_y;
  index_t                    out_index;
  count_t                    out_count;
  logic                      out_clip;
  logic                      out_last;

  // Combinational helpers.
  logic [DiffW-1:0]          abs_dx;
  logic [DiffW-1:0]          abs_dy;
  logic [DiffW-1:0]          mult_a;
  logic [DiffW-1:0]          mult_b;
  logic [ProdW-1:0]          prod;
  logic [CountW:0]           mid_sum;
  count_t                    mid_next;
  logic                      covers;
  count_t                    lo_next;
  count_t                    hi_next;
  logic [CountW:0]           tx;
  logic [CountW:0]           ty;
  logic                      bx;
  logic                      by;
  logic [CountW:0]           n2;
  logic [CountW+1:0]         sum_x;
  logic [CountW+1:0]         sum_y;
  logic                      cx;
  logic                      cy;
  logic signed [DiffW:0]     pnx;
  logic signed [DiffW:0]     pny;
  logic                      pt_load;
  logic                      emit_last;

  // Magnitudes of the differences.
  assign abs_dx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign abs_dy = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

  // Shared multiplier operand select.
  always_comb begin
    case (state)
      S_SQX: begin
        mult_a = abs_dx;
        mult_b = abs_dx;
      end
      S_SQY: begin
        mult_a = abs_dy;
        mult_b = abs_dy;
      end
      S_LEN: begin
        mult_a = DiffW'(mid_next);
        mult_b = DiffW'(spacing);
      end
      S_CMP: begin
        mult_a = len;
        mult_b = len;
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  assign prod = mult_a * mult_b;

  // Binary search step: smallest n whose length covers the segment.
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_next = mid_sum[CountW:1];
  assign covers   = (prod >= d2);
  assign lo_next  = covers ? lo : count_t'(mid + 1'b1);
  assign hi_next  = covers ? mid : hi;

  // Restoring divide step on both axes.
  assign tx = {rx, ax[DiffW-1]};
  assign ty = {ry, ay[DiffW-1]};
  assign bx = (tx >= {1'b0, n});
  assign by = (ty >= {1'b0, n});

  // Point walk step: add the per-point quotient and remainder, carry once.
  assign n2    = {n, 1'b0};
  assign sum_x = {1'b0, rrx} + {1'b0, r2x};
  assign sum_y = {1'b0, rry} + {1'b0, r2y};
  assign cx    = (sum_x >= {1'b0, n2});
  assign cy    = (sum_y >= {1'b0, n2});
  assign pnx   = (DiffW+1)'(px) + qx + (DiffW+1)'(cx);
  assign pny   = (DiffW+1)'(py) + qy + (DiffW+1)'(cy);
  assign pt_load   = (state == S_EMIT) && (!out_valid || pt.ready);
  assign emit_last = (count_t'(k + 1'b1) == n);

  // Sequencer, datapath registers and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      spacing   <= SpacingReset;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        spacing <= cfg_wdata;
      end

      if (pt_load) begin
        out_valid <= 1'b1;
      end else if (pt.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            sx    <= seg.start_x;
            sy    <= seg.start_y;
            dx    <= DiffW'(seg.end_x) - DiffW'(seg.start_x);
            dy    <= DiffW'(seg.end_y) - DiffW'(seg.start_y);
            state <= S_SQX;
          end
        end
        S_SQX: begin
          acc   <= prod;
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= acc + prod;
          lo    <= count_t'(1);
          hi    <= NoneFound;
          state <= S_LEN;
        end
        S_LEN: begin
          mid   <= mid_next;
          len   <= prod[DiffW-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next == hi_next) begin
            if (lo_next == NoneFound) begin
              n    <= MaxCount;
              clip <= 1'b1;
            end else begin
              n    <= lo_next;
              clip <= 1'b0;
            end
            ax    <= abs_dx;
            ay    <= abs_dy;
            rx    <= '0;
            ry    <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else begin
            state <= S_LEN;
          end
        end
        S_DIV: begin
          rx   <= bx ? CountW'(tx - {1'b0, n}) : tx[CountW-1:0];
          ry   <= by ? CountW'(ty - {1'b0, n}) : ty[CountW-1:0];
          ax   <= {ax[DiffW-2:0], bx};
          ay   <= {ay[DiffW-2:0], by};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'(DivSteps - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          // Turn the magnitude division into floor division by n, remainder kept doubled.
          if (!dx[DiffW-1]) begin
            qx  <= (DiffW+1)'(ax);
            r2x <= {rx, 1'b0};
          end else if (rx == '0) begin
            qx  <= -(DiffW+1)'(ax);
            r2x <= '0;
          end else begin
            qx  <= -(DiffW+1)'(ax) - 1'b1;
            r2x <= {CountW'(n - rx), 1'b0};
          end
          if (!dy[DiffW-1]) begin
            qy  <= (DiffW+1)'(ay);
            r2y <= {ry, 1'b0};
          end else if (ry == '0) begin
            qy  <= -(DiffW+1)'(ay);
            r2y <= '0;
          end else begin
            qy  <= -(DiffW+1)'(ay) - 1'b1;
            r2y <= {CountW'(n - ry), 1'b0};
          end
          px    <= DiffW'(sx);
          py    <= DiffW'(sy);
          rrx   <= {1'b0, n};
          rry   <= {1'b0, n};
          k     <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (pt_load) begin
            px        <= pnx[DiffW-1:0];
            py        <= pny[DiffW-1:0];
            rrx       <= cx ? (CountW+1)'(sum_x - {1'b0, n2}) : sum_x[CountW:0];
            rry       <= cy ? (CountW+1)'(sum_y - {1'b0, n2}) : sum_y[CountW:0];
            out_x     <= pnx[23:0];
            out_y     <= pny[23:0];
            out_index <= k[IndexW-1:0];
            out_count <= n;
            out_clip  <= clip;
            out_last  <= emit_last;
            k         <= count_t'(k + 1'b1);
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign seg.ready       = (state == S_IDLE);
  assign pt.valid        = out_valid;
  assign pt.point_x      = out_x;
  assign pt.point_y      = out_y;
  assign pt.sample_index = out_index;
  assign pt.sample_count = out_count;
  assign pt.clipped      = out_clip;
  assign pt.last         = out_last;

endmodule : line_segment_sampler

`default_nettype wire
